// ===== src/isa_pkg.sv =====
// Shared types and constants for the id slot allocator.
`default_nettype none
package isa_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int ID_SPACE  = 256;

   localparam int ID_W      = 8;
   localparam int COUNT_W   = 9;
   localparam int SLOTS     = 256;
   localparam int WORD_W    = 64;
   localparam int NUM_WORDS = SLOTS / WORD_W;
   localparam int WIDX_W    = $clog2(NUM_WORDS);
   localparam int POS_W     = $clog2(WORD_W);

   typedef enum logic [2:0] {
      OP_INSERT_NEXT = 3'd0,
      OP_INSERT_AT   = 3'd1,
      OP_DUPLICATE   = 3'd2,
      OP_REMOVE      = 3'd3,
      OP_LOOKUP      = 3'd4,
      OP_CLEAR       = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_EXISTS  = 3'd2,
      ST_MISSING = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_SCAN,
      FSM_RESP
   } fsm_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic              load;
      logic              exec;
      logic              scan;
      logic [WIDX_W-1:0] word;
   } cmd_type;

endpackage
`default_nettype wire

// ===== src/isa_ctrl.sv =====
// Sequencer for the allocator: capture, execute, lowest-free scan, respond.
`default_nettype none
module isa_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   output logic                 rsp_valid,
   output isa_pkg::cmd_type     cmd
);
   import isa_pkg::*;

   fsm_type            state_ff, state_in;
   logic [WIDX_W-1:0]  word_ff, word_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         word_ff  <= word_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      word_in   = word_ff;
      cmd       = '0;
      cmd.word  = word_ff;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            cmd.exec = 1'b1;
            word_in  = '0;
            state_in = FSM_SCAN;
         end
         FSM_SCAN: begin
            cmd.scan = 1'b1;
            word_in  = word_ff + 1'b1;
            if (word_ff == WIDX_W'(NUM_WORDS - 1)) begin
               state_in = FSM_RESP;
            end
         end
         FSM_RESP: begin
            rsp_valid = 1'b1;
            state_in  = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== src/isa_datapath.sv =====
// Bitmap, used count, lowest-free scan and result registers.
`default_nettype none
module isa_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire isa_pkg::cmd_type             cmd,
   input  wire logic [2:0]                   req_op,
   input  wire logic [isa_pkg::ID_W-1:0]     req_item_id,
   output logic [2:0]                        rsp_status,
   output logic [isa_pkg::ID_W-1:0]          rsp_result_id,
   output logic                              rsp_present,
   output logic [isa_pkg::COUNT_W-1:0]       rsp_used_count,
   output logic [isa_pkg::ID_W-1:0]          rsp_next_free,
   output logic                              rsp_is_full
);
   import isa_pkg::*;

   logic [2:0]          op_ff;
   logic [ID_W-1:0]     id_ff;
   logic [SLOTS-1:0]    map_ff, map_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [ID_W-1:0]     lowest_ff, lowest_in;
   logic                found_ff, found_in;
   logic [2:0]          status_ff, status_in;
   logic [ID_W-1:0]     rid_ff, rid_in;
   logic                present_ff, present_in;

   logic                at_cap, any_free, in_space, slot_used;
   logic [WORD_W-1:0]   free_bits;
   logic                word_has_free;
   logic [POS_W-1:0]    first_pos;

   assign at_cap    = count_ff >= COUNT_W'(MAX_ITEMS);
   assign any_free  = count_ff < COUNT_W'(ID_SPACE);
   assign in_space  = {1'b0, id_ff} < COUNT_W'(ID_SPACE);
   assign slot_used = in_space && map_ff[id_ff];

   // Free slots of the current scan word, limited to the id space.
   always_comb begin
      for (int j = 0; j < WORD_W; j++) begin
         free_bits[j] = !map_ff[{cmd.word, POS_W'(j)}] &&
                        ({1'b0, cmd.word, POS_W'(j)} < COUNT_W'(ID_SPACE));
      end
      first_pos = '0;
      for (int j = WORD_W - 1; j >= 0; j--) begin
         if (free_bits[j]) begin
            first_pos = POS_W'(j);
         end
      end
      word_has_free = |free_bits;
   end

   always_comb begin
      map_in     = map_ff;
      count_in   = count_ff;
      lowest_in  = lowest_ff;
      found_in   = found_ff;
      status_in  = status_ff;
      rid_in     = rid_ff;
      present_in = present_ff;
      if (cmd.exec) begin
         status_in  = ST_OK;
         rid_in     = '0;
         present_in = 1'b0;
         // scan below rebuilds the lowest free id from the updated map
         lowest_in  = '0;
         found_in   = 1'b0;
         case (op_ff)
            OP_INSERT_NEXT: begin
               if (at_cap || !any_free) begin
                  status_in = ST_FULL;
               end else begin
                  rid_in            = lowest_ff;
                  map_in[lowest_ff] = 1'b1;
                  count_in          = count_ff + 1'b1;
               end
            end
            OP_INSERT_AT: begin
               rid_in = id_ff;
               if (at_cap) begin
                  status_in = ST_FULL;
               end else if (!in_space) begin
                  status_in = ST_MISSING;
               end else if (slot_used) begin
                  status_in = ST_EXISTS;
               end else begin
                  map_in[id_ff] = 1'b1;
                  count_in      = count_ff + 1'b1;
               end
            end
            OP_DUPLICATE: begin
               rid_in = id_ff;
               if (at_cap) begin
                  status_in = ST_FULL;
               end else if (!slot_used) begin
                  status_in = ST_MISSING;
               end else if (!any_free) begin
                  status_in = ST_FULL;
               end else begin
                  rid_in            = lowest_ff;
                  map_in[lowest_ff] = 1'b1;
                  count_in          = count_ff + 1'b1;
               end
            end
            OP_REMOVE: begin
               rid_in = id_ff;
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else if (!slot_used) begin
                  status_in = ST_MISSING;
               end else begin
                  map_in[id_ff] = 1'b0;
                  count_in      = count_ff - 1'b1;
               end
            end
            OP_LOOKUP: begin
               rid_in     = id_ff;
               present_in = slot_used;
            end
            OP_CLEAR: begin
               map_in   = '0;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end else if (cmd.scan) begin
         if (!found_ff && word_has_free) begin
            lowest_in = {cmd.word, first_pos};
            found_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff    <= '0;
         count_ff  <= '0;
         lowest_ff <= '0;
         found_ff  <= 1'b0;
      end else begin
         map_ff    <= map_in;
         count_ff  <= count_in;
         lowest_ff <= lowest_in;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_op;
         id_ff <= req_item_id;
      end
      status_ff  <= status_in;
      rid_ff     <= rid_in;
      present_ff <= present_in;
   end

   assign rsp_status     = status_ff;
   assign rsp_result_id  = rid_ff;
   assign rsp_present    = present_ff;
   assign rsp_used_count = count_ff;
   assign rsp_next_free  = lowest_ff;
   assign rsp_is_full    = count_ff == COUNT_W'(MAX_ITEMS);

endmodule
`default_nettype wire

// ===== src/id_slot_allocator.sv =====
// Top level of the bitmap id allocator.
//
// Request channel: drive req_op and req_item_id with start high; the request
// is taken at a clock edge where start is high and busy is low. busy stays
// high until the response has been shown.
// Response channel: rsp_valid is high for exactly one cycle; rsp_status,
// rsp_result_id, rsp_present, rsp_used_count, rsp_next_free and rsp_is_full
// are valid in that cycle. The receiver cannot stall the response.
// Sequence: the operation is applied to the 256-slot bitmap, then the lowest
// free id is rebuilt over the four words of the bitmap, one 64-bit word of the
// bitmap per cycle, then the response cycle follows. busy drops in the cycle
// after the response, so a new request is taken only after the previous one
// has been answered.
// Reset (synchronous, active high) clears the bitmap, the used count and
// the lowest free id; the block is idle right after it.
`default_nettype none
module id_slot_allocator (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [2:0]                req_op,
   input  wire logic [isa_pkg::ID_W-1:0]  req_item_id,
   output logic                           rsp_valid,
   output logic [2:0]                     rsp_status,
   output logic [isa_pkg::ID_W-1:0]       rsp_result_id,
   output logic                           rsp_present,
   output logic [isa_pkg::COUNT_W-1:0]    rsp_used_count,
   output logic [isa_pkg::ID_W-1:0]       rsp_next_free,
   output logic                           rsp_is_full
);
   import isa_pkg::*;

   cmd_type cmd;

   isa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   isa_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_op         (req_op),
      .req_item_id    (req_item_id),
      .rsp_status     (rsp_status),
      .rsp_result_id  (rsp_result_id),
      .rsp_present    (rsp_present),
      .rsp_used_count (rsp_used_count),
      .rsp_next_free  (rsp_next_free),
      .rsp_is_full    (rsp_is_full)
   );

endmodule
`default_nettype wire

// ===== dv/id_slot_allocator_checker.sv =====
// Checker for the id slot allocator: predicts each response and compares it.
`default_nettype none
module id_slot_allocator_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic                        busy,
   input  wire logic [2:0]                  req_op,
   input  wire logic [isa_pkg::ID_W-1:0]    req_item_id,
   input  wire logic                        rsp_valid,
   input  wire logic [2:0]                  rsp_status,
   input  wire logic [isa_pkg::ID_W-1:0]    rsp_result_id,
   input  wire logic                        rsp_present,
   input  wire logic [isa_pkg::COUNT_W-1:0] rsp_used_count,
   input  wire logic [isa_pkg::ID_W-1:0]    rsp_next_free,
   input  wire logic                        rsp_is_full,
   output int                               fail_count,
   output int                               outstanding
);
   import isa_pkg::*;

   typedef struct {
      logic [2:0]         status;
      logic [ID_W-1:0]    result_id;
      logic               present;
      logic [COUNT_W-1:0] used_count;
      logic [ID_W-1:0]    next_free;
      logic               is_full;
   } alloc_result_type;

   logic [SLOTS-1:0]   slot_map;
   logic [COUNT_W-1:0] used_total;
   logic [ID_W-1:0]    lowest_free;
   alloc_result_type   expected_q[$];
   alloc_result_type   want;

   function automatic logic slot_taken(input logic [ID_W-1:0] id);
      return (int'(id) < ID_SPACE) && slot_map[id];
   endfunction

   // Scan downward so the last hit is the lowest free slot; 0 when none.
   function automatic logic [ID_W-1:0] first_free();
      logic [ID_W-1:0] found;
      found = '0;
      for (int i = ID_SPACE - 1; i >= 0; i--)
         if (!slot_map[i]) found = ID_W'(i);
      return found;
   endfunction

   task automatic claim_slot(input logic [ID_W-1:0] id);
      slot_map[id] = 1'b1;
      used_total++;
      lowest_free = first_free();
   endtask

   task automatic predict_alloc(input logic [2:0] op, input logic [ID_W-1:0] id,
                                output alloc_result_type r);
      logic at_cap;
      logic room;
      at_cap      = used_total >= MAX_ITEMS;
      room        = used_total < ID_SPACE;
      r.status    = ST_OK;
      r.result_id = '0;
      r.present   = 1'b0;
      case (op)
         OP_INSERT_NEXT: begin
            if (at_cap || !room) r.status = ST_FULL;
            else begin
               r.result_id = lowest_free;
               claim_slot(lowest_free);
            end
         end
         OP_INSERT_AT: begin
            r.result_id = id;
            if (at_cap) r.status = ST_FULL;
            else if (int'(id) >= ID_SPACE) r.status = ST_MISSING;
            else if (slot_taken(id)) r.status = ST_EXISTS;
            else claim_slot(id);
         end
         OP_DUPLICATE: begin
            r.result_id = id;
            if (at_cap) r.status = ST_FULL;
            else if (!slot_taken(id)) r.status = ST_MISSING;
            else if (!room) r.status = ST_FULL;
            else begin
               r.result_id = lowest_free;
               claim_slot(lowest_free);
            end
         end
         OP_REMOVE: begin
            r.result_id = id;
            // emptiness wins over existence
            if (used_total == 0) r.status = ST_EMPTY;
            else if (!slot_taken(id)) r.status = ST_MISSING;
            else begin
               slot_map[id] = 1'b0;
               used_total--;
               lowest_free = first_free();
            end
         end
         OP_LOOKUP: begin
            r.result_id = id;
            r.present   = slot_taken(id);
         end
         OP_CLEAR: begin
            slot_map    = '0;
            used_total  = '0;
            lowest_free = '0;
         end
         default: ;
      endcase
      r.used_count = used_total;
      r.next_free  = lowest_free;
      r.is_full    = (used_total == MAX_ITEMS);
   endtask

   task automatic compare_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, name, exp_val, act_val);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         slot_map    = '0;
         used_total  = '0;
         lowest_free = '0;
         expected_q.delete();
         outstanding = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               fail_count++;
               $display("%0t: response with no request pending, expected none, %s %0d",
                        $time, "actual id", rsp_result_id);
            end else begin
               want = expected_q.pop_front();
               outstanding--;
               compare_field("status", int'(want.status), int'(rsp_status));
               compare_field("result_id", int'(want.result_id), int'(rsp_result_id));
               compare_field("present", int'(want.present), int'(rsp_present));
               compare_field("used_count", int'(want.used_count), int'(rsp_used_count));
               compare_field("next_free", int'(want.next_free), int'(rsp_next_free));
               compare_field("is_full", int'(want.is_full), int'(rsp_is_full));
            end
         end
         if (start && !busy) begin
            predict_alloc(req_op, req_item_id, want);
            expected_q.push_back(want);
            outstanding++;
         end
      end
   end

endmodule
`default_nettype wire

// ===== dv/id_slot_allocator_tb.sv =====
// Testbench top for the id slot allocator: reset, request stimulus and verdict.
`default_nettype none
module id_slot_allocator_tb;
   import isa_pkg::*;

   // op codes the block treats as no-ops
   localparam logic [2:0] OP_RSVD_6   = 3'd6;
   localparam logic [2:0] OP_RSVD_7   = 3'd7;
   localparam int         RAND_ITEMS  = 1750;
   localparam int         CYCLE_LIMIT = 200000;

   typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_op;
   logic [ID_W-1:0]    req_item_id;
   logic               rsp_valid;
   logic [2:0]         rsp_status;
   logic [ID_W-1:0]    rsp_result_id;
   logic               rsp_present;
   logic [COUNT_W-1:0] rsp_used_count;
   logic [ID_W-1:0]    rsp_next_free;
   logic               rsp_is_full;
   int                 fail_count;
   int                 outstanding;
   int                 cycle_count;
   bit                 gaps_on;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   id_slot_allocator u_top (
      .clock, .reset, .start, .busy, .req_op, .req_item_id,
      .rsp_valid, .rsp_status, .rsp_result_id, .rsp_present,
      .rsp_used_count, .rsp_next_free, .rsp_is_full
   );

   id_slot_allocator_checker u_checker (
      .clock, .reset, .start, .busy, .req_op, .req_item_id,
      .rsp_valid, .rsp_status, .rsp_result_id, .rsp_present,
      .rsp_used_count, .rsp_next_free, .rsp_is_full,
      .fail_count, .outstanding
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Drive at the falling edge, hold until taken, then maybe drop start a while.
   task automatic send_request(input logic [2:0] op, input logic [ID_W-1:0] id);
      @(negedge clock);
      start       <= 1'b1;
      req_op      <= op;
      req_item_id <= id;
      do @(posedge clock); while (busy);
      if (gaps_on && $urandom_range(99) < 18) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(7)) @(negedge clock);
      end
   endtask

   // Mostly low ids so requests keep hitting occupied slots.
   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(99) < 75) return ID_W'($urandom_range(79));
      return ID_W'($urandom_range(255));
   endfunction

   function automatic logic [2:0] pick_op(input phase_kind_type kind);
      int r;
      r = $urandom_range(99);
      case (kind)
         PH_FILL: begin
            if (r < 35) return OP_INSERT_NEXT;
            if (r < 60) return OP_INSERT_AT;
            if (r < 80) return OP_DUPLICATE;
            if (r < 90) return OP_REMOVE;
            if (r < 98) return OP_LOOKUP;
            if (r < 99) return ($urandom_range(1) != 0) ? OP_RSVD_6 : OP_RSVD_7;
            return OP_CLEAR;
         end
         PH_DRAIN: begin
            if (r < 55) return OP_REMOVE;
            if (r < 65) return OP_INSERT_NEXT;
            if (r < 72) return OP_INSERT_AT;
            if (r < 77) return OP_DUPLICATE;
            if (r < 95) return OP_LOOKUP;
            if (r < 98) return ($urandom_range(1) != 0) ? OP_RSVD_6 : OP_RSVD_7;
            return OP_CLEAR;
         end
         default: return 3'($urandom_range(7));
      endcase
   endfunction

   initial begin
      phase_kind_type kind;
      int             sent;
      int             span;
      reset       = 1'b1;
      start       = 1'b0;
      req_op      = OP_INSERT_NEXT;
      req_item_id = '0;
      gaps_on     = 1'b1;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // empty table corners
      send_request(OP_LOOKUP, 8'd0);
      send_request(OP_REMOVE, 8'd0);
      send_request(OP_DUPLICATE, 8'd0);
      // out-of-order insert, then the gap below it must be found
      send_request(OP_INSERT_AT, 8'd255);
      send_request(OP_INSERT_AT, 8'd255);
      send_request(OP_INSERT_NEXT, 8'd0);
      send_request(OP_INSERT_NEXT, 8'd0);
      send_request(OP_INSERT_AT, 8'd5);
      send_request(OP_INSERT_NEXT, 8'd0);
      send_request(OP_DUPLICATE, 8'd255);
      send_request(OP_DUPLICATE, 8'd200);
      send_request(OP_LOOKUP, 8'd255);
      send_request(OP_LOOKUP, 8'd4);
      send_request(OP_REMOVE, 8'd1);
      send_request(OP_INSERT_NEXT, 8'd0);
      send_request(OP_REMOVE, 8'd200);
      send_request(OP_REMOVE, 8'd255);
      send_request(OP_RSVD_6, 8'd0);
      send_request(OP_RSVD_7, 8'd255);
      send_request(OP_CLEAR, 8'd170);
      send_request(OP_LOOKUP, 8'd5);
      send_request(OP_INSERT_AT, 8'd85);
      send_request(OP_REMOVE, 8'd85);

      // phases push toward capacity, toward empty, or wander
      sent = 0;
      while (sent < RAND_ITEMS) begin
         case ($urandom_range(2))
            0:       kind = PH_FILL;
            1:       kind = PH_DRAIN;
            default: kind = PH_MIXED;
         endcase
         span = $urandom_range(150, 40);
         for (int k = 0; k < span && sent < RAND_ITEMS; k++) begin
            gaps_on = !(sent >= 700 && sent < 1000);
            send_request(pick_op(kind), pick_id());
            sent++;
         end
      end

      @(negedge clock);
      start <= 1'b0;
      wait (outstanding == 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
`default_nettype wire
